// ===== hw/rtl/itt_pkg.sv =====
// Shared types and constants for the INI text tokenizer.
// Holds the request structs, token and error codes, and parser phases.
// No dependencies; every other file in this block imports it.
package itt_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character constants.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        PH_LEAD     = 4'd0,
        PH_COMMENT  = 4'd1,
        PH_SEC_OPEN = 4'd2,
        PH_SEC_NAME = 4'd3,
        PH_SEC_GAP  = 4'd4,
        PH_SEC_DONE = 4'd5,
        PH_KEY_NAME = 4'd6,
        PH_KEY_GAP  = 4'd7,
        PH_VAL_LEAD = 4'd8,
        PH_VALUE    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SECTION = 3'd0,
        KIND_KEY     = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_LEAD       = 3'd0,
        ERR_SEC_NAME   = 3'd1,
        ERR_SEC_END    = 3'd2,
        ERR_KEY_NAME   = 3'd3,
        ERR_KEY_VALUE  = 3'd4,
        ERR_VALUE_CHAR = 3'd5,
        ERR_NO_EQUALS  = 3'd6
    } t_err;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        t_kind       token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        t_err        error_code;
        logic        last_of_run;
    } t_out_req;

    // Results produced by one accepted byte, in order, at most two.
    typedef struct packed {
        logic [1:0] n;
        t_out_req   r0;
        t_out_req   r1;
    } t_step;

endpackage

// ===== hw/rtl/itt_parser.sv =====
// Parser state and combinational step logic for the INI text tokenizer.
// Updates line state on every accepted byte and forms up to two results.
// Depends on itt_pkg.
module itt_parser #(
    parameter int OFFSET_BITS = itt_pkg::OFFSET_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  itt_pkg::t_in_req i_req,
    input  logic            i_end_en,
    output itt_pkg::t_step  o_step
);
    import itt_pkg::*;

    localparam int OB = OFFSET_BITS;

    typedef struct packed {
        logic        vld;
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        t_err        code;
    } t_ev;

    typedef struct packed {
        t_phase ph;
        logic   fail;
        t_err   code;
        logic   emit_val;
    } t_close;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_ZERO = 2'd1,
        CNT_ONE  = 2'd2,
        CNT_INC  = 2'd3
    } t_cnt_op;

    typedef struct packed {
        t_phase  ph;
        logic    fail;
        t_err    code;
        logic    emit;
        t_kind   kind;
        logic    set_beg;
        t_cnt_op cnt_op;
        logic    set_lns;
    } t_take;

    t_phase          r_phase, n_phase;
    logic            r_halted, n_halted;
    logic [OB-1:0]   r_off, n_off;
    logic [OB-1:0]   r_beg, n_beg;
    logic [OB-1:0]   r_cnt, n_cnt;
    logic [OB-1:0]   r_lns, n_lns;
    t_ev [2:0]       ev;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_comment(input logic [7:0] c);
        return (c == CH_HASH) || (c == CH_SEMI);
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        logic r;
        r = c[7];
        if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            r = 1'b1;
        end
        if (c == CH_DOT || c == CH_UNDER || c == CH_DASH) begin
            r = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [15:0] to16(input logic [OB-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic t_ev mk_ev(input t_kind k, input logic [OB-1:0] s,
                                  input logic [OB-1:0] l, input t_err e);
        t_ev r;
        r.vld   = 1'b1;
        r.kind  = k;
        r.start = to16(s);
        r.len   = to16(l);
        r.code  = e;
        return r;
    endfunction

    // What a line end does in the given phase.
    function automatic t_close close_fn(input t_phase ph);
        t_close r;
        r = '{ph: PH_LEAD, fail: 1'b0, code: ERR_LEAD, emit_val: 1'b0};
        case (ph)
            PH_SEC_OPEN, PH_SEC_NAME, PH_SEC_GAP: begin
                r.ph   = ph;
                r.fail = 1'b1;
                r.code = ERR_SEC_END;
            end
            PH_KEY_NAME, PH_KEY_GAP: begin
                r.ph   = ph;
                r.fail = 1'b1;
                r.code = ERR_NO_EQUALS;
            end
            PH_VALUE: begin
                r.emit_val = 1'b1;
            end
            default: begin
                r.ph = PH_LEAD;
            end
        endcase
        return r;
    endfunction

    // What an ordinary (non line end) byte does in the given phase.
    function automatic t_take take_fn(input t_phase ph, input logic [7:0] c);
        t_take r;
        logic  blank, cmt, name, ctl;
        blank = is_blank(c);
        cmt   = is_comment(c);
        name  = is_name(c);
        ctl   = c < CH_SPACE;
        r = '{ph: ph, fail: 1'b0, code: ERR_LEAD, emit: 1'b0, kind: KIND_SECTION,
              set_beg: 1'b0, cnt_op: CNT_KEEP, set_lns: 1'b0};
        case (ph)
            PH_LEAD: begin
                if (blank) begin
                end else if (ctl) begin
                    r.fail = 1'b1;
                    r.code = ERR_LEAD;
                end else if (cmt) begin
                    r.ph = PH_COMMENT;
                end else if (c == CH_LBRACK) begin
                    r.ph = PH_SEC_OPEN;
                end else if (!name) begin
                    r.fail = 1'b1;
                    r.code = ERR_KEY_NAME;
                end else begin
                    r.set_beg = 1'b1;
                    r.cnt_op  = CNT_ONE;
                    r.ph      = PH_KEY_NAME;
                end
            end
            PH_COMMENT: begin
            end
            PH_SEC_OPEN: begin
                if (!blank) begin
                    r.set_beg = 1'b1;
                    r.cnt_op  = CNT_ZERO;
                    r.ph      = PH_SEC_NAME;
                    if (c == CH_RBRACK) begin
                        r.emit = 1'b1;
                        r.kind = KIND_SECTION;
                        r.ph   = PH_SEC_DONE;
                    end else if (!name) begin
                        r.fail = 1'b1;
                        r.code = ERR_SEC_NAME;
                    end else begin
                        r.cnt_op = CNT_ONE;
                    end
                end
            end
            PH_SEC_NAME: begin
                if (blank) begin
                    r.ph = PH_SEC_GAP;
                end else if (c == CH_RBRACK) begin
                    r.emit = 1'b1;
                    r.kind = KIND_SECTION;
                    r.ph   = PH_SEC_DONE;
                end else if (!name) begin
                    r.fail = 1'b1;
                    r.code = ERR_SEC_NAME;
                end else begin
                    r.cnt_op = CNT_INC;
                end
            end
            PH_SEC_GAP: begin
                if (blank) begin
                end else if (c != CH_RBRACK) begin
                    r.fail = 1'b1;
                    r.code = ERR_SEC_END;
                end else begin
                    r.emit = 1'b1;
                    r.kind = KIND_SECTION;
                    r.ph   = PH_SEC_DONE;
                end
            end
            PH_SEC_DONE: begin
                if (blank) begin
                end else if (cmt) begin
                    r.ph = PH_COMMENT;
                end else begin
                    r.fail = 1'b1;
                    r.code = ERR_SEC_END;
                end
            end
            PH_KEY_NAME: begin
                if (blank) begin
                    r.ph = PH_KEY_GAP;
                end else if (c == CH_EQUALS) begin
                    r.emit = 1'b1;
                    r.kind = KIND_KEY;
                    r.ph   = PH_VAL_LEAD;
                end else if (!name) begin
                    r.fail = 1'b1;
                    r.code = ERR_KEY_NAME;
                end else begin
                    r.cnt_op = CNT_INC;
                end
            end
            PH_KEY_GAP: begin
                if (blank) begin
                end else if (c != CH_EQUALS) begin
                    r.fail = 1'b1;
                    r.code = ERR_KEY_VALUE;
                end else begin
                    r.emit = 1'b1;
                    r.kind = KIND_KEY;
                    r.ph   = PH_VAL_LEAD;
                end
            end
            PH_VAL_LEAD: begin
                if (blank) begin
                end else if (cmt) begin
                    r.ph = PH_COMMENT;
                end else if (ctl) begin
                    r.fail = 1'b1;
                    r.code = ERR_VALUE_CHAR;
                end else begin
                    r.set_beg = 1'b1;
                    r.set_lns = 1'b1;
                    r.ph      = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (ctl) begin
                    r.fail = 1'b1;
                    r.code = ERR_VALUE_CHAR;
                end else if (cmt) begin
                    r.emit = 1'b1;
                    r.kind = KIND_VALUE;
                    r.ph   = PH_COMMENT;
                end else if (!blank) begin
                    r.set_lns = 1'b1;
                end
            end
            default: begin
                r.ph = PH_LEAD;
            end
        endcase
        return r;
    endfunction

    // Next state and the ordered list of events for this byte.
    always_comb begin : step_logic
        logic [7:0]    c;
        t_phase        ph;
        logic          hlt;
        logic [OB-1:0] off, beg, cnt, lns, pos_fin;
        logic          do_fin;
        t_close        cl;
        t_take         tk;
        c       = i_req.text_byte;
        ph      = r_phase;
        hlt     = r_halted;
        off     = r_off;
        beg     = r_beg;
        cnt     = r_cnt;
        lns     = r_lns;
        do_fin  = 1'b0;
        pos_fin = r_off;
        cl      = close_fn(PH_LEAD);
        tk      = take_fn(PH_COMMENT, c);
        ev      = '0;
        if (i_req.first_byte) begin
            ph  = PH_LEAD;
            hlt = 1'b0;
            off = '0;
            beg = '0;
            cnt = '0;
            lns = '0;
        end
        if (!hlt) begin
            if (c == CH_NUL) begin
                do_fin  = 1'b1;
                pos_fin = off;
            end else begin
                if (c == CH_LF) begin
                    cl = close_fn(ph);
                    if (cl.fail) begin
                        ev[0] = mk_ev(KIND_ERROR, off, '0, cl.code);
                        hlt   = 1'b1;
                    end else begin
                        if (cl.emit_val) begin
                            ev[0] = mk_ev(KIND_VALUE, beg, lns + 1'b1 - beg, ERR_LEAD);
                        end
                        ph = cl.ph;
                    end
                end else begin
                    tk = take_fn(ph, c);
                    if (tk.set_beg) begin
                        beg = off;
                    end
                    case (tk.cnt_op)
                        CNT_ZERO: cnt = '0;
                        CNT_ONE:  cnt = OB'(1);
                        CNT_INC:  cnt = cnt + 1'b1;
                        default:  cnt = cnt;
                    endcase
                    if (tk.set_lns) begin
                        lns = off;
                    end
                    ph = tk.ph;
                    if (tk.fail) begin
                        ev[0] = mk_ev(KIND_ERROR, off, '0, tk.code);
                        hlt   = 1'b1;
                    end else if (tk.emit) begin
                        if (tk.kind == KIND_VALUE) begin
                            ev[0] = mk_ev(KIND_VALUE, beg, lns + 1'b1 - beg, ERR_LEAD);
                        end else begin
                            ev[0] = mk_ev(tk.kind, beg, cnt, ERR_LEAD);
                        end
                    end
                end
                off     = off + 1'b1;
                do_fin  = i_req.last_byte && !hlt;
                pos_fin = off;
            end
            if (do_fin) begin
                cl = close_fn(ph);
                if (cl.fail) begin
                    ev[1] = mk_ev(KIND_ERROR, pos_fin, '0, cl.code);
                end else begin
                    if (cl.emit_val) begin
                        ev[1] = mk_ev(KIND_VALUE, beg, lns + 1'b1 - beg, ERR_LEAD);
                    end
                    ph = cl.ph;
                    if (i_end_en) begin
                        ev[2] = mk_ev(KIND_END, pos_fin, '0, ERR_LEAD);
                    end
                end
                hlt = 1'b1;
            end
        end
        n_phase  = ph;
        n_halted = hlt;
        n_off    = off;
        n_beg    = beg;
        n_cnt    = cnt;
        n_lns    = lns;
    end

    // Packs the events into the result list and marks the final one.
    always_comb begin : result_pack
        logic [1:0] n;
        t_out_req   r;
        n      = 2'd0;
        o_step = '0;
        for (int i = 0; i < 3; i++) begin
            r = '{token_kind: ev[i].kind, token_start: ev[i].start,
                  token_length: ev[i].len, error_code: ev[i].code, last_of_run: 1'b0};
            if (ev[i].vld) begin
                if (n == 2'd0) begin
                    o_step.r0 = r;
                end else if (n == 2'd1) begin
                    o_step.r1 = r;
                end
                if (n != 2'd2) begin
                    n = n + 1'b1;
                end
            end
        end
        o_step.r0.last_of_run = (n == 2'd1);
        o_step.r1.last_of_run = (n == 2'd2);
        o_step.n              = i_accept ? n : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_halted <= 1'b0;
            r_off    <= '0;
            r_beg    <= '0;
            r_cnt    <= '0;
            r_lns    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            r_off    <= n_off;
            r_beg    <= n_beg;
            r_cnt    <= n_cnt;
            r_lns    <= n_lns;
        end
    end

    // A halted parser stays silent until a new text starts.
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_halted && !i_req.first_byte) |-> (o_step.n == 2'd0))
        else $error("halted parser produced a result");

    // Every error halts the parser.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_step.n != 2'd0 && o_step.r0.token_kind == KIND_ERROR) |=> r_halted)
        else $error("error result did not halt the parser");

endmodule

// ===== hw/rtl/itt_res_queue.sv =====
// Result queue for the INI text tokenizer: four entries, two writes a cycle.
// Decouples the byte input from the output channel (one result per cycle unless stalled).
// Depends on itt_pkg.
module itt_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itt_pkg::t_step    i_step,
    input  logic              i_pop_ok,
    output logic              o_valid,
    output itt_pkg::t_out_req o_req,
    output logic              o_room
);
    import itt_pkg::*;

    t_out_req            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign pop     = o_valid && i_pop_ok;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_step.n);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(i_step.n) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_step.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.r0;
        end
        if (i_step.n == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.n != 2'd0) |-> (r_count <= QCNT_W'(QDEPTH) - QCNT_W'(i_step.n)))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QPTR_W'(r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0]))
        else $error("queue pointers disagree with fill count");

endmodule

// ===== hw/rtl/ini_text_tokenizer.sv =====
// INI text tokenizer top level. Results of an accepted byte are written to the queue
// and offered from the next cycle on, one per cycle while i_out_stall is low.
// The input takes one byte per cycle; the parser step is one shallow pass, and the
// input stalls only while the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active low) clears parser state, offset and queue, and sets
// end_token_enable to 1. Depends on itt_pkg, itt_parser and itt_res_queue.
module ini_text_tokenizer #(
    parameter int OFFSET_BITS = itt_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Byte input channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  itt_pkg::t_in_req  i_in_req,
    // Token output channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output itt_pkg::t_out_req o_out_req,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import itt_pkg::*;

    logic   r_end_en;
    logic   in_accept;
    logic   cfg_write;
    logic   room;
    t_step  step;

    // The only register, end_token_enable, sits at address 0. The byte lane
    // bits of the address do not select anything, so every write lands on it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr != 2'b00);
    assign prdata    = {31'd0, r_end_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_en <= 1'b1;
        end else if (cfg_write) begin
            r_end_en <= pwdata[0];
        end
    end

    // A request is taken whenever the queue can absorb the two results that
    // the worst-case byte (last byte closing a value line) can produce. The
    // stall therefore depends only on the fill level, never on the valid.
    assign o_in_stall = !room;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The parser keeps the line state and forms the results of one byte in a
    // single combinational pass; its state registers update on acceptance.
    itt_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_req    (i_in_req),
        .i_end_en (r_end_en),
        .o_step   (step)
    );

    // Results wait here until the output side takes them, in order.
    itt_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_pop_ok (!i_out_stall),
        .o_valid  (o_out_valid),
        .o_req    (o_out_req),
        .o_room   (room)
    );

endmodule
